@@ sv/ddo_pkg.sv @@
`timescale 1ns / 1ps

package ddo_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int TABLE_LEN         = 24;

  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  localparam logic [29:0] GAIN_Q30 = 30'd652032874;
  localparam logic [30:0] PI_Q29   = 31'd1686629713;

  localparam logic [2:0] CFG_RIGHT_DPT = 3'd0;
  localparam logic [2:0] CFG_LEFT_DPT  = 3'd1;
  localparam logic [2:0] CFG_ANGLE_PM  = 3'd2;
  localparam logic [2:0] CFG_SLIP      = 3'd3;
  localparam logic [2:0] CFG_RATE      = 3'd4;
  localparam logic [2:0] CFG_REVERSE   = 3'd5;

  localparam logic [31:0] RIGHT_DPT_RST = 32'd158000;
  localparam logic [31:0] LEFT_DPT_RST  = 32'd158000;
  localparam logic [31:0] ANGLE_PM_RST  = 32'd2908700000;
  localparam logic [15:0] SLIP_RST      = 16'd0;
  localparam logic [9:0]  RATE_RST      = 10'd100;

  typedef struct packed {
    logic               func;
    logic signed [15:0] delta_right;
    logic signed [15:0] delta_left;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [15:0] load_heading;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [15:0] motion_heading;
    logic signed [31:0] linear_speed;
    logic signed [31:0] rotation_speed;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MR, S_ML, S_SUM, S_MA1, S_MA0, S_MAG, S_X0, S_C1, S_C2, S_C3,
    S_C4, S_CORD, S_DXY, S_DVX, S_DVY, S_UPD, S_FIN
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CAPT, OP_MR, OP_ML, OP_SUM, OP_MA1, OP_MA0, OP_MAG,
    OP_X0, OP_C1, OP_C2, OP_C3, OP_C4, OP_CORD, OP_DXY, OP_DVX, OP_DVY,
    OP_UPD, OP_FIN
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic in_load;
    logic cord_last;
    logic out_free;
  } status_t;

endpackage

@@ sv/differential_drive_odometry.sv @@
`timescale 1ns / 1ps
// channel  direction  handshake                payload
// cfg      in         cfg_we_i                 cfg_idx_i, cfg_data_i
// in       in         in_valid_i / in_ready_o  in_i  (ddo_pkg::in_t)
// out      out        out_valid_o / out_ready_i out_o (ddo_pkg::out_t)
//
// An update runs products, rotation and pose update; a load skips to the final step;
// the rotation is one CORDIC iteration a cycle and the products share one multiplier.
// A new request is taken only once the previous result sits in the output register.
// rst_ni is asynchronous: pose and speeds clear, registers take their defaults.
// A stalled output holds the block in its final step until the previous result is taken.

module differential_drive_odometry #(
  parameter int CORDIC_STAGES = ddo_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_BITS    = ddo_pkg::ANGLE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ddo_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ddo_pkg::out_t out_o
);

  ddo_pkg::cmd_t    cmd;
  ddo_pkg::status_t sts;

  ddo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  ddo_dp #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .ANGLE_BITS    (ANGLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .out_ready_i (out_ready_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

@@ sv/ddo_ctrl.sv @@
`timescale 1ns / 1ps

module ddo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  ddo_pkg::status_t  sts_i,
  output logic              in_ready_o,
  output ddo_pkg::cmd_t     cmd_o
);

  ddo_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ddo_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ddo_pkg::S_IDLE: begin
        if (in_valid_i) state_d = sts_i.in_load ? ddo_pkg::S_FIN : ddo_pkg::S_MR;
      end
      ddo_pkg::S_MR:  state_d = ddo_pkg::S_ML;
      ddo_pkg::S_ML:  state_d = ddo_pkg::S_SUM;
      ddo_pkg::S_SUM: state_d = ddo_pkg::S_MA1;
      ddo_pkg::S_MA1: state_d = ddo_pkg::S_MA0;
      ddo_pkg::S_MA0: state_d = ddo_pkg::S_MAG;
      ddo_pkg::S_MAG: state_d = ddo_pkg::S_X0;
      ddo_pkg::S_X0:  state_d = ddo_pkg::S_C1;
      ddo_pkg::S_C1:  state_d = ddo_pkg::S_C2;
      ddo_pkg::S_C2:  state_d = ddo_pkg::S_C3;
      ddo_pkg::S_C3:  state_d = ddo_pkg::S_C4;
      ddo_pkg::S_C4:  state_d = ddo_pkg::S_CORD;
      ddo_pkg::S_CORD: begin
        if (sts_i.cord_last) state_d = ddo_pkg::S_DXY;
      end
      ddo_pkg::S_DXY: state_d = ddo_pkg::S_DVX;
      ddo_pkg::S_DVX: state_d = ddo_pkg::S_DVY;
      ddo_pkg::S_DVY: state_d = ddo_pkg::S_UPD;
      ddo_pkg::S_UPD: state_d = ddo_pkg::S_FIN;
      ddo_pkg::S_FIN: begin
        if (sts_i.out_free) state_d = ddo_pkg::S_IDLE;
      end
      default: state_d = ddo_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = ddo_pkg::OP_NONE;
    case (state_q)
      ddo_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = sts_i.in_load ? ddo_pkg::OP_LOAD : ddo_pkg::OP_CAPT;
      end
      ddo_pkg::S_MR:   cmd_o.op = ddo_pkg::OP_MR;
      ddo_pkg::S_ML:   cmd_o.op = ddo_pkg::OP_ML;
      ddo_pkg::S_SUM:  cmd_o.op = ddo_pkg::OP_SUM;
      ddo_pkg::S_MA1:  cmd_o.op = ddo_pkg::OP_MA1;
      ddo_pkg::S_MA0:  cmd_o.op = ddo_pkg::OP_MA0;
      ddo_pkg::S_MAG:  cmd_o.op = ddo_pkg::OP_MAG;
      ddo_pkg::S_X0:   cmd_o.op = ddo_pkg::OP_X0;
      ddo_pkg::S_C1:   cmd_o.op = ddo_pkg::OP_C1;
      ddo_pkg::S_C2:   cmd_o.op = ddo_pkg::OP_C2;
      ddo_pkg::S_C3:   cmd_o.op = ddo_pkg::OP_C3;
      ddo_pkg::S_C4:   cmd_o.op = ddo_pkg::OP_C4;
      ddo_pkg::S_CORD: cmd_o.op = ddo_pkg::OP_CORD;
      ddo_pkg::S_DXY:  cmd_o.op = ddo_pkg::OP_DXY;
      ddo_pkg::S_DVX:  cmd_o.op = ddo_pkg::OP_DVX;
      ddo_pkg::S_DVY:  cmd_o.op = ddo_pkg::OP_DVY;
      ddo_pkg::S_UPD:  cmd_o.op = ddo_pkg::OP_UPD;
      ddo_pkg::S_FIN: begin
        if (sts_i.out_free) cmd_o.op = ddo_pkg::OP_FIN;
      end
      default: cmd_o.op = ddo_pkg::OP_NONE;
    endcase
  end

endmodule

@@ sv/ddo_dp.sv @@
`timescale 1ns / 1ps

module ddo_dp #(
  parameter int CORDIC_STAGES = ddo_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_BITS    = ddo_pkg::ANGLE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  input  ddo_pkg::in_t      in_i,
  input  ddo_pkg::cmd_t     cmd_i,
  input  logic              out_ready_i,
  output ddo_pkg::status_t  sts_o,
  output logic              out_valid_o,
  output ddo_pkg::out_t     out_o
);

  localparam int XW = 52;
  localparam int CW = $clog2(CORDIC_STAGES);
  localparam int AB = ANGLE_BITS;

  logic [31:0]        rdpt_q, ldpt_q, apm_q;
  logic signed [15:0] slip_q;
  logic [9:0]         rate_q;
  logic               rev_q;

  logic [31:0]        pos_x_q, pos_y_q, speed_q, turn_q;
  logic [15:0]        head_q;

  logic signed [15:0] dr_q, dl_q;
  logic signed [47:0] tr_q;
  logic signed [31:0] mean_q;
  logic [48:0]        m_q;
  logic               neg_q;
  logic [56:0]        p1_q;
  logic [33:0]        mag_q;
  logic signed [33:0] cpi_q;
  logic signed [XW-1:0] x_q, y_q;
  logic [AB-1:0]      z_q;
  logic               flip_q;
  logic [CW-1:0]      cnt_q;
  logic signed [31:0] dx_q, dy_q, devx_q;

  logic signed [35:0] ma, mb;
  logic signed [71:0] p_q;

  logic               out_valid_q;
  ddo_pkg::out_t      out_q;

  logic signed [48:0] sum_w, diff_w;
  logic [81:0]        pfull_w;
  logic signed [34:0] dth_w;
  logic [31:0]        z32_w;
  logic [AB-1:0]      zi_w;
  logic               flip_w;
  logic signed [XW-1:0] xs_w, ys_w, xf_w, yf_w, xr_w, yr_w;
  logic [AB-1:0]      at_w [CORDIC_STAGES];
  logic               out_free;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_atan
    localparam logic [32:0] RND = {1'b0, ddo_pkg::ATAN_TAB[g]} + (33'd1 << (31 - AB));
    assign at_w[g] = RND[31:32-AB];
  end

  function automatic logic [31:0] sat32(input logic signed [71:0] v);
    logic [31:0] r;
    if (v > 72'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -72'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  assign sum_w   = 49'(tr_q) + 49'($signed(p_q[47:0]));
  assign diff_w  = 49'(tr_q) - 49'($signed(p_q[47:0]));
  assign pfull_w = {p1_q, 24'd0} + 82'(p_q[55:0]) + (82'd1 << 47);
  assign dth_w   = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
  assign z32_w   = {head_q, 16'd0};
  assign zi_w    = z32_w[31 -: AB];
  assign flip_w  = zi_w[AB-1] ^ zi_w[AB-2];
  assign xs_w    = x_q >>> cnt_q;
  assign ys_w    = y_q >>> cnt_q;
  assign xf_w    = flip_q ? -x_q : x_q;
  assign yf_w    = flip_q ? -y_q : y_q;
  assign xr_w    = xf_w + XW'(32768);
  assign yr_w    = yf_w + XW'(32768);
  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.in_load   = in_i.func;
  assign sts_o.cord_last = (cnt_q == CW'(CORDIC_STAGES - 1));
  assign sts_o.out_free  = out_free;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      ddo_pkg::OP_MR:  begin ma = 36'(dr_q); mb = $signed({4'd0, rdpt_q}); end
      ddo_pkg::OP_ML:  begin ma = 36'(dl_q); mb = $signed({4'd0, ldpt_q}); end
      ddo_pkg::OP_MA1: begin ma = $signed({11'd0, m_q[48:24]}); mb = $signed({4'd0, apm_q}); end
      ddo_pkg::OP_MA0: begin ma = $signed({12'd0, m_q[23:0]}); mb = $signed({4'd0, apm_q}); end
      ddo_pkg::OP_MAG: begin ma = 36'(mean_q); mb = $signed({6'd0, ddo_pkg::GAIN_Q30}); end
      ddo_pkg::OP_X0:  begin ma = 36'(slip_q); mb = 36'($signed(dth_w[15:0])); end
      ddo_pkg::OP_C1:  begin
        ma = 36'($signed(p_q[31:0]));
        mb = $signed({5'd0, ddo_pkg::PI_Q29});
      end
      ddo_pkg::OP_C2:  begin ma = 36'(mean_q); mb = $signed({26'd0, rate_q}); end
      ddo_pkg::OP_C3:  begin ma = 36'(dth_w); mb = $signed({26'd0, rate_q}); end
      ddo_pkg::OP_DVX: begin ma = 36'(cpi_q); mb = 36'(dy_q); end
      ddo_pkg::OP_DVY: begin ma = 36'(cpi_q); mb = 36'(dx_q); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdpt_q      <= ddo_pkg::RIGHT_DPT_RST;
      ldpt_q      <= ddo_pkg::LEFT_DPT_RST;
      apm_q       <= ddo_pkg::ANGLE_PM_RST;
      slip_q      <= $signed(ddo_pkg::SLIP_RST);
      rate_q      <= ddo_pkg::RATE_RST;
      rev_q       <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      head_q      <= '0;
      speed_q     <= '0;
      turn_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ddo_pkg::CFG_RIGHT_DPT: rdpt_q <= cfg_data_i;
          ddo_pkg::CFG_LEFT_DPT:  ldpt_q <= cfg_data_i;
          ddo_pkg::CFG_ANGLE_PM:  apm_q  <= cfg_data_i;
          ddo_pkg::CFG_SLIP:      slip_q <= $signed(cfg_data_i[15:0]);
          ddo_pkg::CFG_RATE:      rate_q <= cfg_data_i[9:0];
          ddo_pkg::CFG_REVERSE:   rev_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        ddo_pkg::OP_LOAD: begin
          pos_x_q <= in_i.load_x;
          pos_y_q <= in_i.load_y;
          head_q  <= in_i.load_heading;
        end
        ddo_pkg::OP_X0:   cnt_q <= '0;
        ddo_pkg::OP_CORD: cnt_q <= cnt_q + CW'(1);
        ddo_pkg::OP_C3:   speed_q <= sat32(p_q);
        ddo_pkg::OP_C4:   turn_q  <= sat32(p_q);
        ddo_pkg::OP_UPD: begin
          pos_x_q <= pos_x_q + dx_q + devx_q;
          pos_y_q <= pos_y_q + dy_q + p_q[54:23];
          head_q  <= head_q + dth_w[15:0];
        end
        default: ;
      endcase
      if (cmd_i.op == ddo_pkg::OP_FIN) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= ma * mb;
    case (cmd_i.op)
      ddo_pkg::OP_CAPT: begin
        dr_q <= in_i.delta_right;
        dl_q <= in_i.delta_left;
      end
      ddo_pkg::OP_ML:  tr_q <= $signed(p_q[47:0]);
      ddo_pkg::OP_SUM: begin
        mean_q <= sum_w[48:17];
        neg_q  <= diff_w[48];
        m_q    <= diff_w[48] ? 49'(-diff_w) : 49'(diff_w);
      end
      ddo_pkg::OP_MA0: p1_q <= p_q[56:0];
      ddo_pkg::OP_MAG: mag_q <= pfull_w[81:48];
      ddo_pkg::OP_X0: begin
        x_q    <= XW'($signed(p_q[61:14]));
        y_q    <= '0;
        z_q    <= {zi_w[AB-1] ^ flip_w, zi_w[AB-2:0]};
        flip_q <= flip_w;
      end
      ddo_pkg::OP_C2: cpi_q <= $signed(p_q[62:29]);
      ddo_pkg::OP_CORD: begin
        if (!z_q[AB-1]) begin
          x_q <= x_q - ys_w;
          y_q <= y_q + xs_w;
          z_q <= z_q - at_w[cnt_q];
        end else begin
          x_q <= x_q + ys_w;
          y_q <= y_q - xs_w;
          z_q <= z_q + at_w[cnt_q];
        end
      end
      ddo_pkg::OP_DXY: begin
        dx_q <= $signed(xr_w[47:16]);
        dy_q <= $signed(yr_w[47:16]);
      end
      ddo_pkg::OP_DVY: devx_q <= -$signed(p_q[54:23]);
      ddo_pkg::OP_FIN: begin
        out_q.pos_x          <= pos_x_q;
        out_q.pos_y          <= pos_y_q;
        out_q.heading        <= head_q;
        out_q.motion_heading <= head_q + (rev_q ? 16'h8000 : 16'h0000);
        out_q.linear_speed   <= speed_q;
        out_q.rotation_speed <= turn_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam logic [2:0] CFG_SPARE  = 3'd7;
  localparam int         HOLD_LONG  = 400;
  localparam int         STALL_MAX  = 3000;
  localparam int         DRAIN_WAIT = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  ddo_pkg::in_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ddo_pkg::out_t out_res;

  // mirrored registers and pose
  bit [31:0] right_dpt, left_dpt, angle_pm;
  bit signed [15:0] slip;
  bit [9:0] rate;
  bit rev;
  bit [31:0] px, py, spd, turn;
  bit [15:0] hd;

  ddo_pkg::out_t pose_q[$];
  int errors = 0, n_upd = 0, n_load = 0, n_cfg = 0, n_res = 0;
  bit idle_on = 1'b0, long_req = 1'b0;
  int hold_cnt = 0, stall_cnt = 0;

  differential_drive_odometry dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .in_i(in_req), .out_valid_o(out_valid), .out_ready_i(out_ready), .out_o(out_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic ddo_pkg::out_t predict_pose(ddo_pkg::in_t r);
    longint tr, tl, mean, diff, dth, dth16, x, y, xs, ys, tmp, dx, dy, c, cpi, devx, devy;
    longint unsigned m, p1, p0, low, fine, mag;
    bit neg, flip;
    bit [31:0] z, t, mask, half;
    ddo_pkg::out_t o;
    if (r.func) begin
      px = r.load_x;
      py = r.load_y;
      hd = r.load_heading;
    end else begin
      tr = longint'(r.delta_right) * longint'(right_dpt);
      tl = longint'(r.delta_left) * longint'(left_dpt);
      mean = (tr + tl) >>> 17;
      diff = tr - tl;
      neg = diff < 0;
      m = neg ? -diff : diff;
      p1 = (m >> 24) * longint'(angle_pm);
      p0 = (m & 64'hffffff) * longint'(angle_pm);
      low = ((p1 & 64'hff) << 24) + p0;
      fine = (p1 >> 8) + (low >> 32);
      mag = (fine + 64'h8000) >> 16;
      dth = neg ? -longint'(mag) : longint'(mag);
      dth16 = longint'(signed'(dth[15:0]));

      mask = 32'hffffffff << (32 - ddo_pkg::ANGLE_BITS_DEF);
      half = 32'd1 << (31 - ddo_pkg::ANGLE_BITS_DEF);
      z = {hd, 16'h0} & mask;
      flip = (z[31:30] == 2'd1) || (z[31:30] == 2'd2);
      if (flip) z = z + 32'h80000000;
      x = (mean * longint'(ddo_pkg::GAIN_Q30)) >>> 14;
      y = 0;
      for (int i = 0; i < ddo_pkg::CORDIC_STAGES_DEF && i < ddo_pkg::TABLE_LEN; i++) begin
        t = (ddo_pkg::ATAN_TAB[i] + half) & mask;
        xs = x >>> i;
        ys = y >>> i;
        if (!z[31]) begin
          x = x - ys; y = y + xs; z = z - t;
        end else begin
          x = x + ys; y = y - xs; z = z + t;
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      tmp = (x + 32768) >>> 16;
      dx = longint'(signed'(tmp[31:0]));
      tmp = (y + 32768) >>> 16;
      dy = longint'(signed'(tmp[31:0]));

      c = longint'(slip) * dth16;
      cpi = (c * longint'(ddo_pkg::PI_Q29)) >>> 29;
      devx = -((cpi * dy) >>> 23);
      devy = (cpi * dx) >>> 23;
      px = px + dx[31:0] + devx[31:0];
      py = py + dy[31:0] + devy[31:0];
      hd = hd + dth[15:0];
      spd = sat32(mean * longint'(rate));
      turn = sat32(dth * longint'(rate));
    end
    o.pos_x = px;
    o.pos_y = py;
    o.heading = hd;
    o.motion_heading = hd + (rev ? 16'h8000 : 16'h0);
    o.linear_speed = spd;
    o.rotation_speed = turn;
    return o;
  endfunction

  always @(posedge clk) begin
    if (in_valid && in_ready) pose_q.push_back(predict_pose(in_req));
  end

  always @(posedge clk) begin
    ddo_pkg::out_t e;
    if (out_valid && out_ready) begin
      n_res++;
      if (pose_q.size() == 0) begin
        errors++;
        $error("result with no request outstanding");
      end else begin
        e = pose_q.pop_front();
        if (out_res.pos_x !== e.pos_x) begin
          errors++; $error("pos_x exp %0d got %0d", e.pos_x, out_res.pos_x);
        end
        if (out_res.pos_y !== e.pos_y) begin
          errors++; $error("pos_y exp %0d got %0d", e.pos_y, out_res.pos_y);
        end
        if (out_res.heading !== e.heading) begin
          errors++; $error("heading exp %0d got %0d", e.heading, out_res.heading);
        end
        if (out_res.motion_heading !== e.motion_heading) begin
          errors++;
          $error("motion_heading exp %0d got %0d", e.motion_heading, out_res.motion_heading);
        end
        if (out_res.linear_speed !== e.linear_speed) begin
          errors++;
          $error("linear_speed exp %0d got %0d", e.linear_speed, out_res.linear_speed);
        end
        if (out_res.rotation_speed !== e.rotation_speed) begin
          errors++;
          $error("rotation_speed exp %0d got %0d", e.rotation_speed, out_res.rotation_speed);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready = 1'b0;
    end else if (long_req) begin
      long_req = 1'b0;
      hold_cnt = HOLD_LONG;
      out_ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      hold_cnt = $urandom_range(0, 11);
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_MAX) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_request(ddo_pkg::in_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_req = r;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (r.func) n_load++; else n_upd++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    in_valid = 1'b0;
    while (pose_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    case (idx)
      ddo_pkg::CFG_RIGHT_DPT: right_dpt = val;
      ddo_pkg::CFG_LEFT_DPT:  left_dpt = val;
      ddo_pkg::CFG_ANGLE_PM:  angle_pm = val;
      ddo_pkg::CFG_SLIP:      slip = val[15:0];
      ddo_pkg::CFG_RATE:      rate = val[9:0];
      ddo_pkg::CFG_REVERSE:   rev = val[0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic ddo_pkg::in_t update_req(int dr, int dl);
    ddo_pkg::in_t r;
    r = '0;
    r.func = 1'b0;
    r.delta_right = 16'(dr);
    r.delta_left = 16'(dl);
    r.load_x = $urandom;
    r.load_y = $urandom;
    r.load_heading = 16'($urandom);
    return r;
  endfunction

  function automatic ddo_pkg::in_t load_req(int x, int y, int h);
    ddo_pkg::in_t r;
    r = update_req($urandom, $urandom);
    r.func = 1'b1;
    r.load_x = x;
    r.load_y = y;
    r.load_heading = 16'(h);
    return r;
  endfunction

  function automatic ddo_pkg::in_t random_req();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return load_req($urandom, $urandom, $urandom);
    if (k < 3) return update_req($urandom, $urandom);
    return update_req($signed($urandom_range(0, 400)) - 200,
                      $signed($urandom_range(0, 400)) - 200);
  endfunction

  task automatic test_directed();
    send_request(update_req(0, 0));
    send_request(update_req(100, 100));
    send_request(update_req(32767, 32767));
    send_request(update_req(-32768, -32768));
    send_request(update_req(32767, -32768));
    send_request(update_req(-32768, 32767));
    send_request(update_req(50, -50));
    foreach (ddo_pkg::ATAN_TAB[i]) begin
      if (i < 6) begin
        send_request(load_req(0, 0, (i * 16384) - 32768));
        send_request(update_req(300, 200));
      end
    end
    send_request(load_req(32'h7fffffff, 32'h80000000, 32767));
    send_request(update_req(30000, 30000));
    send_request(load_req(32'h80000000, 32'h7fffffff, -32768));
    send_request(update_req(-30000, -29000));
  endtask

  task automatic test_register_extremes();
    write_reg(ddo_pkg::CFG_RIGHT_DPT, 32'hffffffff);
    write_reg(ddo_pkg::CFG_LEFT_DPT, 32'hffffffff);
    write_reg(ddo_pkg::CFG_ANGLE_PM, 32'hffffffff);
    write_reg(ddo_pkg::CFG_SLIP, 32'h7fff);
    write_reg(ddo_pkg::CFG_RATE, 10'd1000);
    write_reg(ddo_pkg::CFG_REVERSE, 1);
    write_reg(CFG_SPARE, 32'hdeadbeef);
    repeat (20) send_request(random_req());
    write_reg(ddo_pkg::CFG_RIGHT_DPT, 0);
    write_reg(ddo_pkg::CFG_LEFT_DPT, 0);
    write_reg(ddo_pkg::CFG_ANGLE_PM, 0);
    write_reg(ddo_pkg::CFG_SLIP, 32'h8000);
    write_reg(ddo_pkg::CFG_RATE, 0);
    write_reg(ddo_pkg::CFG_REVERSE, 0);
    repeat (10) send_request(random_req());
    write_reg(ddo_pkg::CFG_RIGHT_DPT, 32'hffffffff);
    write_reg(ddo_pkg::CFG_RATE, 10'd1023);
    write_reg(ddo_pkg::CFG_SLIP, 32'h8000);
    write_reg(ddo_pkg::CFG_ANGLE_PM, 32'hffffffff);
    repeat (20) send_request(random_req());
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      write_reg(ddo_pkg::CFG_RIGHT_DPT,
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(50000, 400000));
      write_reg(ddo_pkg::CFG_LEFT_DPT,
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(50000, 400000));
      write_reg(ddo_pkg::CFG_ANGLE_PM, $urandom);
      write_reg(ddo_pkg::CFG_SLIP, $urandom);
      write_reg(ddo_pkg::CFG_RATE, $urandom_range(1, 1000));
      write_reg(ddo_pkg::CFG_REVERSE, $urandom);
      idle_on = (p % 4) != 3;
      repeat (per_phase) send_request(random_req());
    end
  endtask

  task automatic test_output_backpressure();
    idle_on = 1'b0;
    long_req = 1'b1;
    repeat (30) send_request(random_req());
  endtask

  initial begin
    right_dpt = ddo_pkg::RIGHT_DPT_RST;
    left_dpt = ddo_pkg::LEFT_DPT_RST;
    angle_pm = ddo_pkg::ANGLE_PM_RST;
    slip = ddo_pkg::SLIP_RST;
    rate = ddo_pkg::RATE_RST;
    rev = 1'b0;
    {px, py, hd, spd, turn} = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    idle_on = 1'b1;
    test_register_extremes();
    test_output_backpressure();
    test_random_phases(7, 200);
    idle_on = 1'b0;
    test_random_phases(1, 100);
    in_valid = 1'b0;
    while (pose_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d updates, %0d pose loads, %0d register writes, %0d results",
             n_upd, n_load, n_cfg, n_res);
    $display("with register extremes, random idling and a long output stall.");
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
